@@ hdl/nearest_rotate_scatter_top_macros.svh @@
// ----------------------------------------------------------------------------
// nearest_rotate_scatter_top_macros
// Assertion macros for the rotation block; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef NEAREST_ROTATE_SCATTER_TOP_MACROS_SVH
`define NEAREST_ROTATE_SCATTER_TOP_MACROS_SVH

`ifndef SYNTH

// antecedent implies consequent, sampled on clk, off while in reset
`define NRS_CHECK_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("nrs check failed: label");

// condition must never hold outside reset
`define NRS_CHECK_NEVER(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("nrs check failed: label");

`else

`define NRS_CHECK_IMPL(label, ante, cons)
`define NRS_CHECK_NEVER(label, cond)

`endif

`endif

@@ hdl/nrs_pkg.sv @@
// ----------------------------------------------------------------------------
// nrs_pkg
// Widths, fixed-point constants and register indexes of the rotation block.
// ----------------------------------------------------------------------------
`default_nettype none

package nrs_pkg;

  localparam int MAX_DIM        = 2048;
  localparam int TRIG_FRAC_BITS = 14;

  localparam int TRIG_W     = 16;
  localparam int DIM_W      = 12;
  localparam int COORD_W    = 11;
  localparam int PIX_W      = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // dx, dy: an unsigned coordinate minus a half dimension, signed
  localparam int DX_W   = COORD_W + 2;
  localparam int PROD_W = DX_W + TRIG_W;
  // two products, the centre term and the half, with headroom
  localparam int ACC_W  = PROD_W + 3;
  // rotated position after dropping the fraction, signed
  localparam int POS_W  = ACC_W - TRIG_FRAC_BITS + 1;

  localparam logic [DIM_W-1:0]  DIM_LIMIT   = DIM_W'(MAX_DIM);
  localparam logic [DIM_W-1:0]  DIM_RESET   = DIM_W'(MAX_DIM);
  localparam logic [TRIG_W-1:0] COS_RESET   = TRIG_W'(1 << TRIG_FRAC_BITS);
  localparam logic [TRIG_W-1:0] SIN_RESET   = '0;
  localparam logic [ACC_W-1:0]  HALF_LSB    = ACC_W'(1) << (TRIG_FRAC_BITS - 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH,
    CFG_IMAGE_HEIGHT,
    CFG_COS_OF_ANGLE,
    CFG_SIN_OF_ANGLE
  } cfg_idx_t;

endpackage

`default_nettype wire

@@ hdl/nearest_rotate_scatter_top.sv @@
// Forward-mapping nearest-neighbor rotation: each source pixel with its column
// and row goes in on start, and at the end of the pipeline the destination
// column, row, the unchanged pixel and an in-bounds flag come out for one cycle
// under out_valid. A new pixel may be started in every cycle while busy is low;
// the four-stage pipeline (offsets, four 13x16 multipliers, sums, rounding and
// bounds test) gives a throughput of one pixel per clock. The receiver cannot
// stall, so results must be taken when out_valid is high. busy is set during
// reset and cleared once rst_n is sampled high, and is low from then on.
// Registers are written through the cfg port, which is always ready, and must
// only change while no pixel is in the pipeline.
// ----------------------------------------------------------------------------
// nearest_rotate_scatter_top
// Rotates pixel positions about the image center in signed Q2.14.
// ----------------------------------------------------------------------------
`default_nettype none

`include "nearest_rotate_scatter_top_macros.svh"

module nearest_rotate_scatter_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [nrs_pkg::COORD_W-1:0]      in_src_col,
  input  logic [nrs_pkg::COORD_W-1:0]      in_src_row,
  input  logic [nrs_pkg::PIX_W-1:0]        in_src_pixel,
  output logic                             out_valid,
  output logic [nrs_pkg::COORD_W-1:0]      out_dst_col,
  output logic [nrs_pkg::COORD_W-1:0]      out_dst_row,
  output logic [nrs_pkg::PIX_W-1:0]        out_dst_pixel,
  output logic                             out_in_bounds,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [nrs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [nrs_pkg::CFG_DATA_W-1:0]   cfg_data
);

  import nrs_pkg::*;

  // truncate toward zero after the half has been added
  function automatic logic signed [POS_W-1:0] trunc_fix(input logic signed [ACC_W-1:0] v);
    logic [ACC_W-1:0]        mag;
    logic signed [POS_W-1:0] q;
    mag = v[ACC_W-1] ? ACC_W'(-v) : ACC_W'(v);
    q   = $signed({1'b0, mag[ACC_W-1:TRIG_FRAC_BITS]});
    return v[ACC_W-1] ? -q : q;
  endfunction

  // configuration registers
  logic [DIM_W-1:0]         cfg_width_r;
  logic [DIM_W-1:0]         cfg_height_r;
  logic signed [TRIG_W-1:0] cfg_cos_r;
  logic signed [TRIG_W-1:0] cfg_sin_r;
  logic                     busy_r;

  logic                     cfg_wr;
  logic                     accept;
  logic [DIM_W-1:0]         w_eff;
  logic [DIM_W-1:0]         h_eff;
  logic [COORD_W-1:0]       ox;
  logic [COORD_W-1:0]       oy;

  // stage 1: offsets from the center
  logic                     s1_valid_r;
  logic signed [DX_W-1:0]   s1_dx_r, s1_dy_r;
  logic [PIX_W-1:0]         s1_pix_r;
  logic signed [DX_W-1:0]   s1_dx_nxt, s1_dy_nxt;

  // stage 2: products
  logic                     s2_valid_r;
  logic signed [PROD_W-1:0] s2_cdx_r, s2_sdy_r, s2_sdx_r, s2_cdy_r;
  logic [PIX_W-1:0]         s2_pix_r;
  logic signed [PROD_W-1:0] s2_cdx_nxt, s2_sdy_nxt, s2_sdx_nxt, s2_cdy_nxt;

  // stage 3: rotated position in fixed point, half already added
  logic                     s3_valid_r;
  logic signed [ACC_W-1:0]  s3_ax_r, s3_ay_r;
  logic [PIX_W-1:0]         s3_pix_r;
  logic signed [ACC_W-1:0]  ox_fix, oy_fix;
  logic signed [ACC_W-1:0]  s3_ax_nxt, s3_ay_nxt;

  // stage 4: rounding and bounds test, output registers
  logic                     out_valid_r;
  logic [COORD_W-1:0]       out_col_r, out_row_r;
  logic [PIX_W-1:0]         out_pix_r;
  logic                     out_inb_r;
  logic signed [POS_W-1:0]  x_pos, y_pos;
  logic signed [POS_W-1:0]  w_pos, h_pos;
  logic                     inb_nxt;
  logic [COORD_W-1:0]       out_col_nxt, out_row_nxt;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign busy      = busy_r;
  assign accept    = start && !busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_width_r  <= DIM_RESET;
      cfg_height_r <= DIM_RESET;
      cfg_cos_r    <= COS_RESET;
      cfg_sin_r    <= SIN_RESET;
      busy_r       <= 1'b1;
    end else begin
      busy_r <= 1'b0;
      if (cfg_wr) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_IMAGE_WIDTH:  cfg_width_r  <= cfg_data[DIM_W-1:0];
          CFG_IMAGE_HEIGHT: cfg_height_r <= cfg_data[DIM_W-1:0];
          CFG_COS_OF_ANGLE: cfg_cos_r    <= $signed(cfg_data[TRIG_W-1:0]);
          CFG_SIN_OF_ANGLE: cfg_sin_r    <= $signed(cfg_data[TRIG_W-1:0]);
          default: ;
        endcase
      end
    end
  end

  // oversized dimensions count as the largest supported one
  assign w_eff = (cfg_width_r > DIM_LIMIT) ? DIM_LIMIT : cfg_width_r;
  assign h_eff = (cfg_height_r > DIM_LIMIT) ? DIM_LIMIT : cfg_height_r;
  assign ox    = w_eff[DIM_W-1:1];
  assign oy    = h_eff[DIM_W-1:1];

  assign s1_dx_nxt = $signed({{(DX_W-COORD_W){1'b0}}, in_src_col})
                   - $signed({{(DX_W-COORD_W){1'b0}}, ox});
  assign s1_dy_nxt = $signed({{(DX_W-COORD_W){1'b0}}, oy})
                   - $signed({{(DX_W-COORD_W){1'b0}}, in_src_row});

  assign s2_cdx_nxt = s1_dx_r * cfg_cos_r;
  assign s2_sdy_nxt = s1_dy_r * cfg_sin_r;
  assign s2_sdx_nxt = s1_dx_r * cfg_sin_r;
  assign s2_cdy_nxt = s1_dy_r * cfg_cos_r;

  assign ox_fix    = $signed(ACC_W'({ox, {TRIG_FRAC_BITS{1'b0}}}));
  assign oy_fix    = $signed(ACC_W'({oy, {TRIG_FRAC_BITS{1'b0}}}));
  assign s3_ax_nxt = ACC_W'(s2_cdx_r) - ACC_W'(s2_sdy_r) + ox_fix + $signed(HALF_LSB);
  assign s3_ay_nxt = oy_fix + $signed(HALF_LSB) - ACC_W'(s2_sdx_r) - ACC_W'(s2_cdy_r);

  assign x_pos   = trunc_fix(s3_ax_r);
  assign y_pos   = trunc_fix(s3_ay_r);
  assign w_pos   = $signed({{(POS_W-DIM_W){1'b0}}, w_eff});
  assign h_pos   = $signed({{(POS_W-DIM_W){1'b0}}, h_eff});
  assign inb_nxt = (x_pos >= 0) && (x_pos < w_pos) && (y_pos >= 0) && (y_pos < h_pos);

  assign out_col_nxt = inb_nxt ? x_pos[COORD_W-1:0] : '0;
  assign out_row_nxt = inb_nxt ? y_pos[COORD_W-1:0] : '0;

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= accept;
      s2_valid_r  <= s1_valid_r;
      s3_valid_r  <= s2_valid_r;
      out_valid_r <= s3_valid_r;
    end
  end

  // payload, advances every cycle
  always_ff @(posedge clk) begin
    s1_dx_r   <= s1_dx_nxt;
    s1_dy_r   <= s1_dy_nxt;
    s1_pix_r  <= in_src_pixel;
    s2_cdx_r  <= s2_cdx_nxt;
    s2_sdy_r  <= s2_sdy_nxt;
    s2_sdx_r  <= s2_sdx_nxt;
    s2_cdy_r  <= s2_cdy_nxt;
    s2_pix_r  <= s1_pix_r;
    s3_ax_r   <= s3_ax_nxt;
    s3_ay_r   <= s3_ay_nxt;
    s3_pix_r  <= s2_pix_r;
    out_col_r <= out_col_nxt;
    out_row_r <= out_row_nxt;
    out_pix_r <= s3_pix_r;
    out_inb_r <= inb_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_dst_col   = out_col_r;
  assign out_dst_row   = out_row_r;
  assign out_dst_pixel = out_pix_r;
  assign out_in_bounds = out_inb_r;

  `NRS_CHECK_IMPL(a_latency, accept, ##4 out_valid)
  `NRS_CHECK_IMPL(a_pixel_kept, accept, ##4 (out_dst_pixel == $past(in_src_pixel, 4)))
  `NRS_CHECK_NEVER(a_oob_zero, out_valid && !out_in_bounds && (out_dst_col != '0 || out_dst_row != '0))

endmodule

`default_nettype wire
